[design/lsrc_pkg.sv]
// Shared constants for the linear interpolation sample rate converter.
`timescale 1ns / 1ps
`default_nettype none

package lsrc_pkg;

  // Default datapath widths
  localparam int SampleBitsDef = 16;
  localparam int FracBitsDef   = 16;

  // Rate step register: unsigned, 16 fraction bits, 20 bits wide
  localparam int StepBits = 20;
  localparam logic [StepBits-1:0] RateStepReset = 20'd65536;

  // Channel count register
  localparam int ChanBits = 2;
  localparam logic [ChanBits-1:0] ChanMono       = 2'd1;
  localparam logic [ChanBits-1:0] ChanCountReset = 2'd2;

  // Cap on results per input frame
  localparam int MaxResults = 64;

  // Configuration port
  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits  = StepBits;
  localparam logic [CfgIndexBits-1:0] RegRateStep     = 2'd0;
  localparam logic [CfgIndexBits-1:0] RegChannelCount = 2'd1;

endpackage : lsrc_pkg

`default_nettype wire

[design/linear_sample_rate_converter_unit.sv]
// Top level of the streaming linear interpolation sample rate converter.
`timescale 1ns / 1ps
`default_nettype none

// Linear interpolation resampler, one stereo frame per input transaction.
//  - s_axis: input frames. tdata = {sample_right, sample_left}, left in the low bits.
//  - m_axis: output frames. tdata = {out_right, out_left}; tlast marks the final
//    output caused by one input frame.
//  - cfg: register writes (index 0 rate_step, index 1 channel_count), always
//    ready; write only while the block is idle.
// Per output the two channel differences go through a bit-serial shift-add
// multiplier, one phase fraction bit per cycle, both channels side by side;
// each output passes a check step, FRAC_BITS multiply steps and an emit
// step. One input frame yields n outputs (n up to 64), and the receiver can
// stall the output register between them, holding the engine in its emit step.
// The first frame after reset only primes the held frame.
// The output register decouples the sides: a new input is taken while the
// last output of the previous frame still waits for tready. When the receiver
// stalls, the engine waits in its emit step with the next result ready.
// Reset (rst_ni low, asynchronous) clears the phase, the held frame, the
// primed flag and the output valid, and loads rate_step = 1.0, stereo.
module linear_sample_rate_converter_unit
  import lsrc_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef,
  parameter int FRAC_BITS   = FracBitsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Input frames
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // [SAMPLE_BITS-1:0] sample_left, [2*SAMPLE_BITS-1:SAMPLE_BITS] sample_right, zero pad
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // Output frames
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // [SAMPLE_BITS-1:0] out_left, [2*SAMPLE_BITS-1:SAMPLE_BITS] out_right, zero pad
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,
  // Configuration writes
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [CfgDataBits-1:0]  cfg_data_i
);

  localparam int DataBits  = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int PhaseBits = ((StepBits > FRAC_BITS) ? StepBits : FRAC_BITS) + 1;
  localparam int BitCntW   = $clog2(FRAC_BITS);
  localparam int CntW      = $clog2(MaxResults + 1);
  localparam logic [PhaseBits-1:0] PhaseOne = PhaseBits'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_EMIT
  } state_e;

  state_e                  state_q;
  logic signed [SAMPLE_BITS-1:0] cur_l_q, cur_r_q;
  logic signed [SAMPLE_BITS-1:0] held_l_q, held_r_q;
  logic                    have_held_q;
  logic [PhaseBits-1:0]    phase_q;
  logic [StepBits-1:0]     step_q;
  logic [ChanBits-1:0]     chan_q;
  logic [SAMPLE_BITS:0]    diff_l_q, diff_r_q;
  logic [SAMPLE_BITS:0]    acc_l_q, acc_r_q;
  logic [FRAC_BITS-1:0]    frac_q;
  logic [BitCntW-1:0]      bit_cnt_q;
  logic [CntW-1:0]         cnt_q;
  logic [SAMPLE_BITS-1:0]  out_l_q, out_r_q;
  logic                    out_last_q;
  logic                    out_valid_q;

  logic                    in_fire;
  logic                    out_free;
  logic                    phase_below;
  logic                    cap_hit;
  logic [SAMPLE_BITS+1:0]  sum_l, sum_r;
  logic [SAMPLE_BITS:0]    acc_l_d, acc_r_d;
  logic [SAMPLE_BITS-1:0]  res_l, res_r;
  logic [PhaseBits-1:0]    phase_d;
  logic                    last_d;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign phase_below = (phase_q < PhaseOne);
  assign cap_hit     = (cnt_q == CntW'(MaxResults));

  // One shift-add step: floor((acc + bit * diff) / 2); after FRAC_BITS steps
  // the accumulator holds floor(diff * frac / 2^FRAC_BITS).
  assign sum_l   = {acc_l_q[SAMPLE_BITS], acc_l_q}
                 + (frac_q[0] ? {diff_l_q[SAMPLE_BITS], diff_l_q} : '0);
  assign sum_r   = {acc_r_q[SAMPLE_BITS], acc_r_q}
                 + (frac_q[0] ? {diff_r_q[SAMPLE_BITS], diff_r_q} : '0);
  assign acc_l_d = sum_l[SAMPLE_BITS+1:1];
  assign acc_r_d = sum_r[SAMPLE_BITS+1:1];

  // The result lies between held and new sample, so low bits suffice
  assign res_l = held_l_q + acc_l_q[SAMPLE_BITS-1:0];
  assign res_r = (chan_q == ChanMono) ? res_l : (held_r_q + acc_r_q[SAMPLE_BITS-1:0]);

  // Phase after this output; tlast when the loop ends here
  assign phase_d = phase_q + PhaseBits'(step_q);
  assign last_d  = (phase_d >= PhaseOne) || (cnt_q == CntW'(MaxResults - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_held_q <= 1'b0;
      held_l_q    <= '0;
      held_r_q    <= '0;
      cur_l_q     <= '0;
      cur_r_q     <= '0;
      diff_l_q    <= '0;
      diff_r_q    <= '0;
      acc_l_q     <= '0;
      acc_r_q     <= '0;
      frac_q      <= '0;
      phase_q     <= '0;
      step_q      <= RateStepReset;
      chan_q      <= ChanCountReset;
      out_l_q     <= '0;
      out_r_q     <= '0;
      out_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      bit_cnt_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegRateStep:     step_q <= cfg_data_i[StepBits-1:0];
          RegChannelCount: chan_q <= cfg_data_i[ChanBits-1:0];
          default: ;
        endcase
      end

      // the emit step reloads the output register itself
      if (out_valid_q && m_axis_tready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cur_l_q <= s_axis_tdata[SAMPLE_BITS-1:0];
            cur_r_q <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            cnt_q   <= '0;
            if (!have_held_q) begin
              // priming frame: store only
              held_l_q    <= s_axis_tdata[SAMPLE_BITS-1:0];
              held_r_q    <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
              have_held_q <= 1'b1;
            end else begin
              state_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (phase_below && !cap_hit) begin
            diff_l_q  <= {cur_l_q[SAMPLE_BITS-1], cur_l_q}
                       - {held_l_q[SAMPLE_BITS-1], held_l_q};
            diff_r_q  <= {cur_r_q[SAMPLE_BITS-1], cur_r_q}
                       - {held_r_q[SAMPLE_BITS-1], held_r_q};
            acc_l_q   <= '0;
            acc_r_q   <= '0;
            frac_q    <= phase_q[FRAC_BITS-1:0];
            bit_cnt_q <= '0;
            state_q   <= S_MUL;
          end else begin
            // end of run: drop one, or clear when the cap cut it short
            phase_q  <= phase_below ? '0 : (phase_q - PhaseOne);
            held_l_q <= cur_l_q;
            held_r_q <= cur_r_q;
            state_q  <= S_IDLE;
          end
        end
        S_MUL: begin
          acc_l_q   <= acc_l_d;
          acc_r_q   <= acc_r_d;
          frac_q    <= frac_q >> 1;
          bit_cnt_q <= bit_cnt_q + BitCntW'(1);
          if (bit_cnt_q == BitCntW'(FRAC_BITS - 1)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_l_q     <= res_l;
            out_r_q     <= res_r;
            out_last_q  <= last_d;
            out_valid_q <= 1'b1;
            phase_q     <= phase_d;
            cnt_q       <= cnt_q + CntW'(1);
            state_q     <= S_CHECK;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DataBits'({out_r_q, out_l_q});
  assign m_axis_tlast  = out_last_q;

  // Multiply only runs for a phase below one
  a_mul_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> phase_q < PhaseOne)
    else $error("multiply step with phase at or above one");

  // The stored phase never reaches its top bit between frames
  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !phase_q[PhaseBits-1])
    else $error("stored phase out of range");

  // The 64th output of a frame carries tlast
  a_cap_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && out_free && cnt_q == CntW'(MaxResults - 1)
    |=> m_axis_tvalid && m_axis_tlast)
    else $error("capped run without tlast");

  // Priming frame stores and returns to idle at once
  a_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !have_held_q |=> have_held_q && state_q == S_IDLE)
    else $error("priming frame not handled");

endmodule : linear_sample_rate_converter_unit

`default_nettype wire
